FILE: rtl/gdcu_pkg.sv
// Gregorian date calendar unit: shared constants and lookup tables.
// Used by gdcu_zeller and gregorian_date_calendar_unit; no dependencies.
`default_nettype none

package gdcu_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int MLEN_W  = 5;
	localparam int WDAY_W  = 3;
	localparam int WEEK_W  = 6;
	localparam int DOY_W   = 9;
	localparam int ZSUM_W  = 11;

	typedef logic [MONTH_W-1:0] month_t;

	localparam month_t MONTH_JAN = 4'd1;
	localparam month_t MONTH_FEB = 4'd2;
	localparam month_t MONTH_MAR = 4'd3;

	// floor(x / 100) = (x * RECIP_100) >> 24 for x below 2**15
	localparam logic [17:0] RECIP_100 = 18'd167773;
	// floor(x / 7) = (x * RECIP_7) >> 16 for x below 2**11
	localparam logic [13:0] RECIP_7   = 14'd9363;

	localparam logic [WEEK_W-1:0] WEEK_WRAP  = 6'd53;
	localparam logic [WEEK_W-1:0] WEEK_FIRST = 6'd1;
	localparam logic [DOY_W-1:0]  YEAR_DAYS  = 9'd365;
	localparam logic [MLEN_W-1:0] FEB_LEAP   = 5'd29;

	// days in month, common year; codes outside 1..12 give 0
	localparam logic [MLEN_W-1:0] MONTH_DAYS [16] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
	};

	// days before the first of the month, common year
	localparam logic [DOY_W-1:0] CUM_DAYS [16] = '{
		9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
	};

	// floor(13 * (mm + 1) / 5), with January and February counted as months 13 and 14
	localparam logic [5:0] ZELLER_MTERM [16] = '{
		6'd33, 6'd36, 6'd39, 6'd10, 6'd13, 6'd15, 6'd18, 6'd20,
		6'd23, 6'd26, 6'd28, 6'd31, 6'd33, 6'd36, 6'd39, 6'd41
	};

endpackage

`default_nettype wire

FILE: rtl/gdcu_zeller.sv
// Zeller weekday of a first of month: sum and mod-7 quotient are registered,
// the weekday follows from the registers. Depends on gdcu_pkg.
`default_nettype none

module gdcu_zeller import gdcu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              ld,
	input  wire logic [7:0]        j,
	input  wire logic [6:0]        k,
	input  wire logic [5:0]        month_term,
	output logic      [WDAY_W-1:0] weekday
);

	logic [ZSUM_W-1:0] sum;
	logic [24:0]       prod;
	logic [ZSUM_W-1:0] sum_s3;
	logic [7:0]        q7_s3;
	logic [ZSUM_W-1:0] rem_full;
	logic [2:0]        h;

	assign sum = 11'd1 + 11'(month_term) + 11'(k) + 11'(k[6:2]) + 11'(j[7:2])
		+ 11'({j, 2'b00}) + 11'(j);
	assign prod = 25'(sum) * 25'(RECIP_7);

	always_ff @(posedge clk) begin
		if (ld) begin
			sum_s3 <= sum;
			q7_s3  <= prod[23:16];
		end
	end

	assign rem_full = sum_s3 - (11'({q7_s3, 3'b000}) - 11'(q7_s3));
	assign h        = rem_full[2:0];

	// h counts from Saturday; remap so Monday is 1
	assign weekday = (h >= 3'd2) ? h - 3'd1 : h + 3'd6;

endmodule

`default_nettype wire

FILE: rtl/gregorian_date_calendar_unit.sv
// Gregorian date calendar unit: leap flag, month length, weekday of the first
// of the month and a simplified week number for one date per word.
// Throughput: one word per cycle; the five register stages stall only when all hold
// words and out_stall is high.
// Reset: arst_n clears all valid bits; payload registers are not reset.
`default_nettype none

module gregorian_date_calendar_unit import gdcu_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [YEAR_W-1:0]  year_value,
	input  wire logic [MONTH_W-1:0] month_value,
	input  wire logic [DAY_W-1:0]   day_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    leap_flag,
	output logic      [MLEN_W-1:0]  month_length,
	output logic      [WDAY_W-1:0]  first_weekday,
	output logic      [WEEK_W-1:0]  week_index
);

	logic v1_s1, v2_s2, v3_s3, v4_s4, out_valid_q;
	logic ld1, ld2, ld3, ld4, ld_out;

	assign ld_out   = !out_valid_q || !out_stall;
	assign ld4      = !v4_s4 || ld_out;
	assign ld3      = !v3_s3 || ld4;
	assign ld2      = !v2_s2 || ld3;
	assign ld1      = !v1_s1 || ld2;
	assign in_stall = !ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			v4_s4       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld1)    v1_s1       <= in_valid;
			if (ld2)    v2_s2       <= v1_s1;
			if (ld3)    v3_s3       <= v2_s2;
			if (ld4)    v4_s4       <= v3_s3;
			if (ld_out) out_valid_q <= v4_s4;
		end
	end

	// ---- stage 1: input register
	logic [YEAR_W-1:0]  year_s1;
	month_t             month_s1;
	logic [DAY_W-1:0]   day_s1;

	always_ff @(posedge clk) begin
		if (ld1) begin
			year_s1  <= year_value;
			month_s1 <= month_value;
			day_s1   <= day_value;
		end
	end

	// ---- stage 2: year / 100
	logic [31:0]        prod100;
	logic [YEAR_W-1:0]  year_s2;
	month_t             month_s2;
	logic [DAY_W-1:0]   day_s2;
	logic [7:0]         q100_s2;

	assign prod100 = 32'(year_s1) * 32'(RECIP_100);

	always_ff @(posedge clk) begin
		if (ld2) begin
			year_s2  <= year_s1;
			month_s2 <= month_s1;
			day_s2   <= day_s1;
			q100_s2  <= prod100[31:24];
		end
	end

	// ---- stage 3: leap, month length, day of year, Zeller sums
	logic [14:0]        hund;
	logic [YEAR_W-1:0]  r100_full;
	logic [6:0]         r100;
	logic               leap_b;
	logic               early;
	logic [7:0]         jan1_j, mon_j;
	logic [6:0]         jan1_k, mon_k;
	logic [MLEN_W-1:0]  mlen_b;
	logic [DOY_W-1:0]   doy_b;

	assign hund      = 15'(q100_s2) * 15'(7'd100);
	assign r100_full = year_s2 - hund[13:0];
	assign r100      = r100_full[6:0];

	assign leap_b = ((year_s2[1:0] == 2'b00) && (r100 != 7'd0))
		|| ((r100 == 7'd0) && (q100_s2[1:0] == 2'b00));

	// year + 399 for January and February (Zeller shifts them into the prior year)
	assign jan1_j = (r100 == 7'd0) ? q100_s2 + 8'd3 : q100_s2 + 8'd4;
	assign jan1_k = (r100 == 7'd0) ? 7'd99 : r100 - 7'd1;
	assign early  = month_s2 < MONTH_MAR;
	assign mon_j  = early ? jan1_j : q100_s2 + 8'd4;
	assign mon_k  = early ? jan1_k : r100;

	assign mlen_b = ((month_s2 == MONTH_FEB) && leap_b) ? FEB_LEAP : MONTH_DAYS[month_s2];
	assign doy_b  = CUM_DAYS[month_s2] + 9'(day_s2)
		+ 9'(leap_b && (month_s2 >= MONTH_MAR));

	logic               leap_s3;
	logic [MLEN_W-1:0]  mlen_s3;
	logic [DOY_W-1:0]   doy_s3;
	logic [WDAY_W-1:0]  mon_wd, jan1_wd;

	always_ff @(posedge clk) begin
		if (ld3) begin
			leap_s3 <= leap_b;
			mlen_s3 <= mlen_b;
			doy_s3  <= doy_b;
		end
	end

	gdcu_zeller u_zeller_month (
		.clk        (clk),
		.ld         (ld3),
		.j          (mon_j),
		.k          (mon_k),
		.month_term (ZELLER_MTERM[month_s2]),
		.weekday    (mon_wd)
	);

	gdcu_zeller u_zeller_jan1 (
		.clk        (clk),
		.ld         (ld3),
		.j          (jan1_j),
		.k          (jan1_k),
		.month_term (ZELLER_MTERM[MONTH_JAN]),
		.weekday    (jan1_wd)
	);

	// ---- stage 4: week quotient
	logic [DOY_W-1:0]   wsum, wm1;
	logic [22:0]        prodw;
	logic               leap_s4;
	logic [MLEN_W-1:0]  mlen_s4;
	logic [WDAY_W-1:0]  first_s4;
	logic [DOY_W-1:0]   doy_s4;
	logic [WEEK_W-1:0]  wq_s4;
	logic               wzero_s4;

	assign wsum  = doy_s3 + 9'(jan1_wd) - 9'd1;
	assign wm1   = wsum - 9'd1;
	assign prodw = 23'(wm1) * 23'(RECIP_7);

	always_ff @(posedge clk) begin
		if (ld4) begin
			leap_s4  <= leap_s3;
			mlen_s4  <= mlen_s3;
			first_s4 <= mon_wd;
			doy_s4   <= doy_s3;
			wq_s4    <= prodw[21:16];
			wzero_s4 <= (wsum == 9'd0);
		end
	end

	// ---- output register: fold week 53 in the last seven days back to week 1
	logic [WEEK_W-1:0]  wk_raw, wk;
	logic [DOY_W-1:0]   ylen;
	logic               leap_q;
	logic [MLEN_W-1:0]  mlen_q;
	logic [WDAY_W-1:0]  first_q;
	logic [WEEK_W-1:0]  week_q;

	assign wk_raw = wzero_s4 ? WEEK_FIRST : wq_s4 + 6'd1;
	assign ylen   = YEAR_DAYS + 9'(leap_s4);
	assign wk     = ((wk_raw == WEEK_WRAP) && (doy_s4 > ylen - 9'd7)) ? WEEK_FIRST : wk_raw;

	always_ff @(posedge clk) begin
		if (ld_out) begin
			leap_q  <= leap_s4;
			mlen_q  <= mlen_s4;
			first_q <= first_s4;
			week_q  <= wk;
		end
	end

	assign out_valid     = out_valid_q;
	assign leap_flag     = leap_q;
	assign month_length  = mlen_q;
	assign first_weekday = first_q;
	assign week_index    = week_q;

	// ---- checks
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v1_s1 && v2_s2 && v3_s3 && v4_s4 && out_valid_q && out_stall))
		else $error("input stalled while a pipeline stage is free");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (first_weekday != 3'd0))
		else $error("weekday out of range");

	a_feb_leap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (month_length == FEB_LEAP)) |-> leap_flag)
		else $error("29-day month without leap year");

	a_mlen_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((month_length == 5'd0) || (month_length >= 5'd28)))
		else $error("month length out of range");

	a_week_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (week_index != 6'd0))
		else $error("week number zero");

endmodule

`default_nettype wire
